FILE: hdl/playfair_digraph_encrypt_core_macros.svh
// Assertion helpers; the using module must have i_clk and i_rst_n.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_CORE_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define PFE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_LETTER = 2'd1;
    localparam logic [1:0] REQ_END    = 2'd2;

    localparam logic [4:0] ALPHA       = 5'd26;
    localparam logic [4:0] SQ_CELLS    = 5'd25;
    localparam logic [4:0] SQ_DIM      = 5'd5;
    localparam logic [2:0] DIM_LAST    = 3'd4;
    localparam logic [4:0] LETTER_I    = 5'd8;
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [5:0] FILL_OFFSET = 6'd15;
    localparam logic [5:0] ALPHA_W     = 6'd26;

    localparam logic [4:0] VOWELS [5] = '{5'd0, 5'd4, 5'd8, 5'd14, 5'd20};

    typedef struct packed {
        logic       is_load;
        logic [4:0] cell_index;
        logic [4:0] load_letter;
        logic [4:0] let_a;
        logic [4:0] let_b;
        logic       low_a;
        logic       low_b;
    } t_stage;

    typedef struct packed {
        logic [4:0] oa;
        logic [4:0] ob;
    } t_cells;

    function automatic logic [4:0] fold_j(input logic [4:0] x);
        return (x == LETTER_J) ? LETTER_I : x;
    endfunction

    function automatic logic [4:0] filler_of(input logic [4:0] x, input logic bump);
        logic [5:0] s;
        logic [4:0] f;
        logic       hit;
        s = {1'b0, x} + FILL_OFFSET;
        f = (s >= ALPHA_W) ? 5'(s - ALPHA_W) : s[4:0];
        hit = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (f == VOWELS[i]) begin
                hit = 1'b1;
            end
        end
        if (bump && hit) begin
            f = f + 5'd1;
        end
        return fold_j(f);
    endfunction

    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] p, input logic [2:0] r);
        logic [4:0] t;
        t = p - 5'(5'(r) * SQ_DIM);
        return t[2:0];
    endfunction

    function automatic logic [2:0] step5(input logic [2:0] v);
        return (v >= DIM_LAST) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
        return 5'(5'(r) * SQ_DIM) + 5'(c);
    endfunction

    function automatic t_cells locate(input logic [4:0] pa, input logic [4:0] pb);
        logic [2:0] ra, ca, rb, cb;
        t_cells     res;
        ra = pos_row(pa);
        ca = pos_col(pa, ra);
        rb = pos_row(pb);
        cb = pos_col(pb, rb);
        if (ca == cb) begin
            res.oa = cell_at(step5(ra), ca);
            res.ob = cell_at(step5(rb), cb);
        end else if (ra == rb) begin
            res.oa = cell_at(ra, step5(ca));
            res.ob = cell_at(rb, step5(cb));
        end else begin
            res.oa = cell_at(ra, cb);
            res.ob = cell_at(rb, ca);
        end
        return res;
    endfunction

endpackage

FILE: hdl/pfe_req_if.sv
`timescale 1ns / 1ps

interface pfe_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [4:0] cell_index;
    logic [4:0] letter;
    logic       is_lower;

    modport source (output valid, req_type, cell_index, letter, is_lower, input ready);
    modport sink   (input valid, req_type, cell_index, letter, is_lower, output ready);
endinterface

FILE: hdl/pfe_res_if.sv
`timescale 1ns / 1ps

interface pfe_res_if;
    logic       valid;
    logic       ready;
    logic [4:0] cipher_letter;
    logic       out_lower;
    logic       last;

    modport source (output valid, cipher_letter, out_lower, last, input ready);
    modport sink   (input valid, cipher_letter, out_lower, last, output ready);
endinterface

FILE: hdl/playfair_digraph_encrypt_core.sv
// Channel  | Dir | Payload                                   | Transfer
// i_req    | in  | req_type, cell_index, letter, is_lower    | valid & ready
// o_res    | out | cipher_letter, out_lower, last            | valid & ready
//
// Accepts one request per cycle unless stalled; each digraph yields two
// results, one per cycle while o_res.ready is high, so the single output
// register sets the sustained digraph rate. A digraph's first result passes
// the position read at transfer, the cell read, then the output register.
// Reset (i_rst_n low, synchronous) drops the held letter and all stage
// valids; the key square and position tables are undefined until loaded.
// A stalled o_res holds the output register and backs up through both stages
// to i_req.ready.
`timescale 1ns / 1ps
`include "playfair_digraph_encrypt_core_macros.svh"

module playfair_digraph_encrypt_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfe_req_if.sink   i_req,
    pfe_res_if.source o_res
);

    logic             take;
    logic             push;
    pfe_pkg::t_stage  item;
    pfe_pkg::t_stage  r_a;
    logic             r_va;
    logic             n_va;
    logic             r_vb;
    logic             n_vb;
    logic             r_low_a;
    logic             r_low_b;
    logic             a_go;
    logic             a_free;
    logic             b_free;
    logic             out_free;
    logic             pos_we;
    logic [4:0]       pos_a;
    logic [4:0]       pos_b;
    logic             cell_we;
    logic             cell_re;
    pfe_pkg::t_cells  cells;
    logic [4:0]       sq_a;
    logic [4:0]       sq_b;

    assign b_free      = !r_vb || out_free;
    assign a_go        = r_va && (r_a.is_load || b_free);
    assign a_free      = !r_va || a_go;
    assign i_req.ready = a_free;
    assign take        = i_req.valid && a_free;

    pfe_pair u_pair (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_req_type   (i_req.req_type),
        .i_cell_index (i_req.cell_index),
        .i_letter     (i_req.letter),
        .i_is_lower   (i_req.is_lower),
        .o_push       (push),
        .o_item       (item)
    );

    assign pos_we = take && i_req.req_type == pfe_pkg::REQ_LOAD
                    && i_req.cell_index < pfe_pkg::SQ_CELLS
                    && i_req.letter < pfe_pkg::ALPHA;

    pfe_ram #(.WIDTH(5), .DEPTH(26)) u_pos_ram (
        .i_clk    (i_clk),
        .i_we     (pos_we),
        .i_waddr  (i_req.letter),
        .i_wdata  (i_req.cell_index),
        .i_re     (push && !item.is_load),
        .i_raddr0 (item.let_a),
        .i_raddr1 (item.let_b),
        .o_rdata0 (pos_a),
        .o_rdata1 (pos_b)
    );

    always_comb begin
        n_va = r_va;
        if (push) begin
            n_va = 1'b1;
        end else if (a_go) begin
            n_va = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_a <= item;
        end
    end

    assign cells   = pfe_pkg::locate(pos_a, pos_b);
    assign cell_we = a_go && r_a.is_load && r_a.cell_index < pfe_pkg::SQ_CELLS;
    assign cell_re = a_go && !r_a.is_load;

    pfe_ram #(.WIDTH(5), .DEPTH(25)) u_cell_ram (
        .i_clk    (i_clk),
        .i_we     (cell_we),
        .i_waddr  (r_a.cell_index),
        .i_wdata  (r_a.load_letter),
        .i_re     (cell_re),
        .i_raddr0 (cells.oa),
        .i_raddr1 (cells.ob),
        .o_rdata0 (sq_a),
        .o_rdata1 (sq_b)
    );

    always_comb begin
        n_vb = r_vb;
        if (cell_re) begin
            n_vb = 1'b1;
        end else if (out_free) begin
            n_vb = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_re) begin
            r_low_a <= r_a.low_a;
            r_low_b <= r_a.low_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= n_va;
            r_vb <= n_vb;
        end
    end

    pfe_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_vb && out_free),
        .i_let_a (sq_a),
        .i_let_b (sq_b),
        .i_low_a (r_low_a),
        .i_low_b (r_low_b),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    `PFE_ASSERT_NEXT(a_second_half, o_res.valid && !o_res.last, o_res.valid,
                     "digraph cut after first letter")
    `PFE_ASSERT_NEXT(a_stage_b_hold, r_vb && !out_free, r_vb,
                     "cell stage dropped while output busy")
    `PFE_ASSERT_SAME(a_no_push_stalled, push, a_free, "push into occupied stage")

endmodule

FILE: hdl/pfe_ram.sv
`timescale 1ns / 1ps

module pfe_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

FILE: hdl/pfe_pair.sv
`timescale 1ns / 1ps
`include "playfair_digraph_encrypt_core_macros.svh"

module pfe_pair (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [1:0]     i_req_type,
    input  logic [4:0]     i_cell_index,
    input  logic [4:0]     i_letter,
    input  logic           i_is_lower,
    output logic           o_push,
    output pfe_pkg::t_stage o_item
);

    logic       r_pend_valid;
    logic [4:0] r_pend_letter;
    logic       r_pend_lower;
    logic       n_pend_valid;
    logic [4:0] n_pend_letter;
    logic       n_pend_lower;
    logic [4:0] folded;

    assign folded = pfe_pkg::fold_j(i_letter);

    always_comb begin
        n_pend_valid        = r_pend_valid;
        n_pend_letter       = r_pend_letter;
        n_pend_lower        = r_pend_lower;
        o_push              = 1'b0;
        o_item.is_load      = 1'b0;
        o_item.cell_index   = i_cell_index;
        o_item.load_letter  = i_letter;
        o_item.let_a        = r_pend_letter;
        o_item.let_b        = folded;
        o_item.low_a        = r_pend_lower;
        o_item.low_b        = i_is_lower;
        if (i_take) begin
            unique case (i_req_type)
                pfe_pkg::REQ_LOAD: begin
                    o_push         = 1'b1;
                    o_item.is_load = 1'b1;
                end
                pfe_pkg::REQ_LETTER: begin
                    if (i_letter < pfe_pkg::ALPHA) begin
                        if (!r_pend_valid) begin
                            n_pend_valid  = 1'b1;
                            n_pend_letter = folded;
                            n_pend_lower  = i_is_lower;
                        end else if (folded == r_pend_letter) begin
                            o_push        = 1'b1;
                            o_item.let_b  = pfe_pkg::filler_of(r_pend_letter, 1'b1);
                            o_item.low_b  = 1'b0;
                            n_pend_letter = folded;
                            n_pend_lower  = i_is_lower;
                        end else begin
                            o_push        = 1'b1;
                            n_pend_valid  = 1'b0;
                            n_pend_letter = '0;
                            n_pend_lower  = 1'b0;
                        end
                    end
                end
                pfe_pkg::REQ_END: begin
                    o_push        = r_pend_valid;
                    o_item.let_b  = pfe_pkg::filler_of(r_pend_letter, 1'b0);
                    o_item.low_b  = 1'b0;
                    n_pend_valid  = 1'b0;
                    n_pend_letter = '0;
                    n_pend_lower  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid  <= 1'b0;
            r_pend_letter <= '0;
            r_pend_lower  <= 1'b0;
        end else begin
            r_pend_valid  <= n_pend_valid;
            r_pend_letter <= n_pend_letter;
            r_pend_lower  <= n_pend_lower;
        end
    end

    `PFE_ASSERT_NEXT(a_end_clears, i_take && i_req_type == pfe_pkg::REQ_END, !r_pend_valid, "end item left a held letter")
    `PFE_ASSERT_SAME(a_no_j_out, o_push && !o_item.is_load, o_item.let_b != pfe_pkg::LETTER_J && o_item.let_a != pfe_pkg::LETTER_J, "unfolded J in digraph")

endmodule

FILE: hdl/pfe_out.sv
`timescale 1ns / 1ps

module pfe_out (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [4:0] i_let_a,
    input  logic [4:0] i_let_b,
    input  logic       i_low_a,
    input  logic       i_low_b,
    output logic       o_free,
    pfe_res_if.source  o_res
);

    logic       r_valid;
    logic       r_half;
    logic [4:0] r_let_a;
    logic [4:0] r_let_b;
    logic       r_low_a;
    logic       r_low_b;
    logic       n_valid;
    logic       n_half;

    assign o_free = !r_valid || (r_half && o_res.ready);

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        if (i_load) begin
            n_valid = 1'b1;
            n_half  = 1'b0;
        end else if (r_valid && o_res.ready) begin
            n_valid = !r_half;
            n_half  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_let_a <= i_let_a;
            r_let_b <= i_let_b;
            r_low_a <= i_low_a;
            r_low_b <= i_low_b;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.cipher_letter = r_half ? r_let_b : r_let_a;
    assign o_res.out_lower     = r_half ? r_low_b : r_low_a;
    assign o_res.last          = r_half;

endmodule

FILE: bench/playfair_digraph_encrypt_core_test.sv
`timescale 1ns / 1ps

module playfair_digraph_encrypt_core_test;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int TOTAL_REQS = 1050;
    localparam int QUIET_FROM = 920;
    localparam int HOLD_AT = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic [4:0] letter;
        logic       lower;
        logic       last;
    } t_cipher;

    class digraph_tracker;
        logic [4:0] cells [25];
        logic [4:0] where [26];
        bit         held_valid;
        logic [4:0] held_letter;
        bit         held_lower;
        t_cipher    due [$];
        int         errors;

        function new();
            held_valid = 0;
            held_letter = '0;
            held_lower = 0;
            errors = 0;
        endfunction

        function logic [4:0] filler_for(logic [4:0] x, bit bump);
            int f;
            bit hit;
            f = (int'(x) + 15) % int'(pfe_pkg::ALPHA);
            hit = 0;
            for (int i = 0; i < 5; i++) begin
                if (f == int'(pfe_pkg::VOWELS[i])) begin
                    hit = 1;
                end
            end
            if (bump && hit) begin
                f = f + 1;
            end
            if (f == int'(pfe_pkg::LETTER_J)) begin
                f = int'(pfe_pkg::LETTER_I);
            end
            return 5'(f);
        endfunction

        function void encipher_pair(logic [4:0] a, bit al, logic [4:0] b, bit bl);
            int pa, pb, ra, ca, rb, cb, oa, ob;
            t_cipher c;
            pa = int'(where[a]) % int'(pfe_pkg::SQ_CELLS);
            pb = int'(where[b]) % int'(pfe_pkg::SQ_CELLS);
            ra = pa / int'(pfe_pkg::SQ_DIM);
            ca = pa % int'(pfe_pkg::SQ_DIM);
            rb = pb / int'(pfe_pkg::SQ_DIM);
            cb = pb % int'(pfe_pkg::SQ_DIM);
            if (ca == cb) begin
                oa = ((ra + 1) % int'(pfe_pkg::SQ_DIM)) * int'(pfe_pkg::SQ_DIM) + ca;
                ob = ((rb + 1) % int'(pfe_pkg::SQ_DIM)) * int'(pfe_pkg::SQ_DIM) + cb;
            end else if (ra == rb) begin
                oa = ra * int'(pfe_pkg::SQ_DIM) + (ca + 1) % int'(pfe_pkg::SQ_DIM);
                ob = rb * int'(pfe_pkg::SQ_DIM) + (cb + 1) % int'(pfe_pkg::SQ_DIM);
            end else begin
                oa = ra * int'(pfe_pkg::SQ_DIM) + cb;
                ob = rb * int'(pfe_pkg::SQ_DIM) + ca;
            end
            c.letter = cells[oa];
            c.lower = al;
            c.last = 1'b0;
            due.push_back(c);
            c.letter = cells[ob];
            c.lower = bl;
            c.last = 1'b1;
            due.push_back(c);
        endfunction

        function void note_request(logic [1:0] kind, logic [4:0] cell_idx,
                                   logic [4:0] let_in, bit low);
            logic [4:0] x;
            case (kind)
                pfe_pkg::REQ_LOAD: begin
                    if (cell_idx < pfe_pkg::SQ_CELLS) begin
                        cells[cell_idx] = let_in;
                        if (let_in < pfe_pkg::ALPHA) begin
                            where[let_in] = cell_idx;
                        end
                    end
                end
                pfe_pkg::REQ_LETTER: begin
                    if (let_in < pfe_pkg::ALPHA) begin
                        x = (let_in == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : let_in;
                        if (!held_valid) begin
                            held_valid = 1;
                            held_letter = x;
                            held_lower = low;
                        end else if (x == held_letter) begin
                            encipher_pair(held_letter, held_lower,
                                          filler_for(held_letter, 1'b1), 1'b0);
                            held_lower = low;
                        end else begin
                            encipher_pair(held_letter, held_lower, x, low);
                            held_valid = 0;
                            held_letter = '0;
                            held_lower = 0;
                        end
                    end
                end
                pfe_pkg::REQ_END: begin
                    if (held_valid) begin
                        encipher_pair(held_letter, held_lower,
                                      filler_for(held_letter, 1'b0), 1'b0);
                    end
                    held_valid = 0;
                    held_letter = '0;
                    held_lower = 0;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_cipher(logic [4:0] letter, logic lower, logic last);
            t_cipher want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0b/%0b",
                             $time, letter, lower, last);
                end
            end else begin
                want = due.pop_front();
                if (want.letter !== letter || want.lower !== lower || want.last !== last) begin
                    errors++;
                    if (errors <= REPORT_CAP) begin
                        $display("%0t: mismatch, expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                                 $time, want.letter, want.lower, want.last,
                                 letter, lower, last);
                    end
                end
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pfe_req_if req_ch ();
    pfe_res_if res_ch ();

    playfair_digraph_encrypt_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    digraph_tracker tracker;
    int  n_sent = 0;
    int  cycles = 0;
    bit  quiet = 0;
    bit  in_hold = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            tracker.check_cipher(res_ch.cipher_letter, res_ch.out_lower, res_ch.last);
        end
    end

    // Output side: random stall bursts, plus one long hold-off to back up the pipe.
    initial begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                in_hold = 1;
                res_ch.ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                in_hold = 0;
                res_ch.ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                in_hold = 0;
                res_ch.ready = 1'b0;
            end else begin
                in_hold = 0;
                res_ch.ready = 1'b1;
            end
        end
    end

    task automatic push_request(logic [1:0] kind, logic [4:0] cell_idx, logic [4:0] let_in,
                                logic low);
        int gap;
        gap = 0;
        if (!quiet && !in_hold && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = kind;
        req_ch.cell_index = cell_idx;
        req_ch.letter = let_in;
        req_ch.is_lower = low;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        tracker.note_request(kind, cell_idx, let_in, low);
        n_sent++;
    endtask

    task automatic send_letter(logic [4:0] let_in, logic low);
        push_request(pfe_pkg::REQ_LETTER, 5'($urandom_range(0, 31)), let_in, low);
    endtask

    task automatic send_end();
        push_request(pfe_pkg::REQ_END, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)));
    endtask

    // Fill every cell with the 25 letters other than J, optionally shuffled.
    task automatic load_square(bit shuffle);
        logic [4:0] order [25];
        logic [4:0] t;
        int n;
        int j;
        n = 0;
        for (int i = 0; i < 26; i++) begin
            if (5'(i) != pfe_pkg::LETTER_J) begin
                order[n] = 5'(i);
                n++;
            end
        end
        if (shuffle) begin
            for (int i = 24; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = order[i];
                order[i] = order[j];
                order[j] = t;
            end
        end
        for (int i = 0; i < 25; i++) begin
            push_request(pfe_pkg::REQ_LOAD, 5'(i), order[i], 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_message();
        logic [4:0] pool [3];
        logic [4:0] lt;
        int len;
        bit narrow;
        len = $urandom_range(1, 12);
        narrow = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < 3; i++) begin
            pool[i] = 5'($urandom_range(0, 25));
        end
        for (int k = 0; k < len; k++) begin
            lt = narrow ? pool[$urandom_range(0, 2)] : 5'($urandom_range(0, 25));
            send_letter(lt, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) != 0) begin
            send_end();
        end
    endtask

    initial begin
        int r;
        tracker = new();
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = pfe_pkg::REQ_LOAD;
        req_ch.cell_index = '0;
        req_ch.letter = '0;
        req_ch.is_lower = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        load_square(1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd5, 1'b1);
        send_letter(5'd4, 1'b1);
        send_letter(5'd0, 1'b0);
        send_letter(5'd21, 1'b0);
        send_letter(5'd0, 1'b1);
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b1);
        send_letter(5'd11, 1'b1);
        send_letter(5'd11, 1'b0);
        send_letter(5'd11, 1'b1);
        send_letter(5'd12, 1'b0);
        send_letter(pfe_pkg::LETTER_J, 1'b0);
        send_letter(pfe_pkg::LETTER_I, 1'b1);
        send_letter(5'd19, 1'b0);
        send_letter(5'd19, 1'b1);
        send_letter(5'd19, 1'b0);
        send_end();
        send_end();
        send_letter(5'd20, 1'b0);
        send_end();
        send_letter(5'd31, 1'b1);
        push_request(REQ_NONE, 5'd31, 5'd31, 1'b1);
        push_request(pfe_pkg::REQ_LOAD, 5'd31, 5'd3, 1'b0);
        push_request(pfe_pkg::REQ_LOAD, 5'd24, 5'd31, 1'b1);
        push_request(pfe_pkg::REQ_LOAD, 5'd0, 5'd25, 1'b0);
        send_letter(5'd24, 1'b0);
        send_letter(5'd23, 1'b1);
        send_letter(5'd25, 1'b1);
        send_end();

        load_square(1'b1);
        while (n_sent < TOTAL_REQS) begin
            quiet = (n_sent >= QUIET_FROM);
            r = $urandom_range(0, 99);
            if (r < 4) begin
                load_square(1'b1);
            end else if (r < 10) begin
                push_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                             5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end else begin
                send_message();
            end
        end
        send_end();

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (tracker.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
